>>> src/bpcr_pkg.sv
// ----------------------------------------------------------------------------
// bpcr_pkg
// Types, widths and helpers shared by the box pair collision resolver.
// ----------------------------------------------------------------------------
package bpcr_pkg;

	localparam int CW  = 24;       // coordinate width, signed
	localparam int SW  = CW - 1;   // box size width, unsigned
	localparam int FTW = 16;       // frame time width, unsigned Q0.16
	localparam int MW  = CW + 1;   // separation magnitude width
	localparam int DW  = CW + 2;   // edge difference width, signed
	localparam int EW  = CW + 3;   // lossless sum width before clamping

	localparam logic [FTW-1:0] FT_RESET = FTW'(1092);
	localparam logic [SW-1:0]  SL_RESET = SW'(256);

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [SW-1:0]        size_t;

	typedef enum logic [2:0] {
		SIDE_NONE = 3'd0,
		SIDE_PX   = 3'd1,
		SIDE_NX   = 3'd2,
		SIDE_PY   = 3'd3,
		SIDE_NY   = 3'd4
	} side_t;

	typedef enum logic [1:0] {
		CFG_Y_DOWN       = 2'd0,
		CFG_FRAME_TIME   = 2'd1,
		CFG_SMOOTH_LIMIT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		coord_t a_left;
		coord_t a_top;
		size_t  a_width;
		size_t  a_height;
		coord_t b_left;
		coord_t b_top;
		size_t  b_width;
		size_t  b_height;
		coord_t a_vel_x;
		coord_t a_vel_y;
		coord_t b_vel_x;
		coord_t b_vel_y;
	} box_in_t;

	typedef struct packed {
		logic   hit;
		coord_t new_a_left;
		coord_t new_a_top;
		coord_t new_b_left;
		coord_t new_b_top;
		coord_t new_a_vel_x;
		coord_t new_a_vel_y;
		coord_t new_b_vel_x;
		coord_t new_b_vel_y;
		side_t  contact_side;
		coord_t contact_x;
		coord_t contact_y;
	} box_out_t;

	typedef struct packed {
		logic          hit;
		side_t         side;
		logic [MW-1:0] mag;
	} push_t;

	function automatic logic signed [EW-1:0] ext_coord(input coord_t c);
		return $signed({{(EW-CW){c[CW-1]}}, c});
	endfunction

	function automatic coord_t sat_coord(input logic signed [EW-1:0] v);
		logic in_range;
		in_range = (&v[EW-1:CW-1]) || !(|v[EW-1:CW-1]);
		if (in_range) begin
			return v[CW-1:0];
		end else if (v[EW-1]) begin
			return $signed({1'b1, {(CW-1){1'b0}}});
		end else begin
			return $signed({1'b0, {(CW-1){1'b1}}});
		end
	endfunction

endpackage

>>> src/bpcr_apply.sv
// ----------------------------------------------------------------------------
// bpcr_apply
// Applies the push to both boxes, clamps velocities moving into the contact,
// and forms the contact point. Pure logic, registered by the caller.
// ----------------------------------------------------------------------------
module bpcr_apply (
	input  bpcr_pkg::box_in_t            pair,
	input  bpcr_pkg::push_t              ctl,
	input  logic signed [bpcr_pkg::DW-1:0] csum,
	input  bpcr_pkg::coord_t             cmin,
	output bpcr_pkg::box_out_t           res
);
	import bpcr_pkg::*;

	logic signed [EW-1:0] mag_e;
	logic signed [EW-1:0] tx;
	logic signed [EW-1:0] ty;
	logic signed [EW-1:0] cs_e;
	logic signed [EW-1:0] cx_e;
	coord_t avx, avy, bvx, bvy;

	always_comb begin
		mag_e = $signed({{(EW-MW){1'b0}}, ctl.mag});
		tx = '0;
		ty = '0;
		case (ctl.side)
			SIDE_PX: tx = -mag_e;
			SIDE_NX: tx = mag_e;
			SIDE_PY: ty = -mag_e;
			SIDE_NY: ty = mag_e;
			default: begin
				tx = '0;
				ty = '0;
			end
		endcase
	end

	always_comb begin
		avx = pair.a_vel_x;
		avy = pair.a_vel_y;
		bvx = pair.b_vel_x;
		bvy = pair.b_vel_y;
		case (ctl.side)
			SIDE_PX: begin
				if (avx > 0) avx = '0;
				if (bvx < 0) bvx = '0;
			end
			SIDE_NX: begin
				if (avx < 0) avx = '0;
				if (bvx > 0) bvx = '0;
			end
			SIDE_PY: begin
				if (avy > 0) avy = '0;
				if (bvy < 0) bvy = '0;
			end
			SIDE_NY: begin
				if (avy < 0) avy = '0;
				if (bvy > 0) bvy = '0;
			end
			default: begin
			end
		endcase
	end

	// floor of half the span sum
	assign cs_e = $signed({{(EW-DW){csum[DW-1]}}, csum});
	assign cx_e = cs_e >>> 1;

	always_comb begin
		res.hit          = ctl.hit;
		res.new_a_left   = sat_coord(ext_coord(pair.a_left) + tx);
		res.new_a_top    = sat_coord(ext_coord(pair.a_top) + ty);
		res.new_b_left   = sat_coord(ext_coord(pair.b_left) - tx);
		res.new_b_top    = sat_coord(ext_coord(pair.b_top) - ty);
		res.new_a_vel_x  = avx;
		res.new_a_vel_y  = avy;
		res.new_b_vel_x  = bvx;
		res.new_b_vel_y  = bvy;
		res.contact_side = ctl.side;
		res.contact_x    = ctl.hit ? sat_coord(cx_e) : '0;
		res.contact_y    = ctl.hit ? cmin : '0;
	end

endmodule

>>> src/box_pair_collision_resolve.sv
// ----------------------------------------------------------------------------
// box_pair_collision_resolve
// Overlap test and minimum-translation push for a pair of axis-aligned boxes.
// Throughput: one pair per cycle while res_stall is low; six pipeline stages,
// each stage holds while the next is full and stalled.
// Reset clears all stage valid bits; y_down=0, frame_time=1092,
// smooth_limit=256.
// ----------------------------------------------------------------------------
module box_pair_collision_resolve (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_idx,
	input  logic [bpcr_pkg::SW-1:0] cfg_wdata,
	input  logic                   pair_valid,
	output logic                   pair_stall,
	input  bpcr_pkg::box_in_t      pair,
	output logic                   res_valid,
	input  logic                   res_stall,
	output bpcr_pkg::box_out_t     res
);
	import bpcr_pkg::*;

	// configuration
	logic           y_down_q;
	logic [FTW-1:0] frame_time_q;
	logic [SW-1:0]  smooth_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_down_q       <= 1'b0;
			frame_time_q   <= FT_RESET;
			smooth_limit_q <= SL_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_Y_DOWN:       y_down_q       <= cfg_wdata[0];
				CFG_FRAME_TIME:   frame_time_q   <= cfg_wdata[FTW-1:0];
				CFG_SMOOTH_LIMIT: smooth_limit_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// stage control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || !res_stall;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pair_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pair_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1: box edges
	box_in_t            p_s1;
	logic signed [CW:0] ar_s1, br_s1, ab_s1, bb_s1, atd_s1, btd_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			p_s1   <= pair;
			ar_s1  <= $signed({pair.a_left[CW-1], pair.a_left}) + $signed({2'b00, pair.a_width});
			br_s1  <= $signed({pair.b_left[CW-1], pair.b_left}) + $signed({2'b00, pair.b_width});
			ab_s1  <= $signed({pair.a_top[CW-1], pair.a_top}) - $signed({2'b00, pair.a_height});
			bb_s1  <= $signed({pair.b_top[CW-1], pair.b_top}) - $signed({2'b00, pair.b_height});
			atd_s1 <= $signed({pair.a_top[CW-1], pair.a_top}) + $signed({2'b00, pair.a_height});
			btd_s1 <= $signed({pair.b_top[CW-1], pair.b_top}) + $signed({2'b00, pair.b_height});
		end
	end

	// stage 2: overlap test, edge differences, contact span
	logic signed [CW:0]   al1, at1, bl1, bt1;
	logic signed [CW:0]   lmax1, rmin1;
	logic                 hit_x1, hit_y1;
	box_in_t              p_s2;
	logic                 hit_s2, ltx_s2, lty_s2;
	logic signed [DW-1:0] dax_s2, dbx_s2, day_s2, dby_s2, sum_s2;
	coord_t               cy_s2;

	assign al1 = $signed({p_s1.a_left[CW-1], p_s1.a_left});
	assign at1 = $signed({p_s1.a_top[CW-1], p_s1.a_top});
	assign bl1 = $signed({p_s1.b_left[CW-1], p_s1.b_left});
	assign bt1 = $signed({p_s1.b_top[CW-1], p_s1.b_top});
	assign lmax1 = (al1 < bl1) ? bl1 : al1;
	assign rmin1 = (ar_s1 < br_s1) ? ar_s1 : br_s1;
	assign hit_x1 = !((bl1 > ar_s1) || (al1 > br_s1));
	assign hit_y1 = y_down_q ? !((bt1 > atd_s1) || (at1 > btd_s1))
	                         : !((bt1 < ab_s1) || (at1 < bb_s1));

	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2   <= p_s1;
			hit_s2 <= hit_x1 && hit_y1;
			ltx_s2 <= al1 < bl1;
			lty_s2 <= at1 < bt1;
			dax_s2 <= $signed({al1[CW], al1}) - $signed({br_s1[CW], br_s1});
			dbx_s2 <= $signed({bl1[CW], bl1}) - $signed({ar_s1[CW], ar_s1});
			day_s2 <= $signed({at1[CW], at1}) - $signed({bb_s1[CW], bb_s1});
			dby_s2 <= $signed({bt1[CW], bt1}) - $signed({ab_s1[CW], ab_s1});
			sum_s2 <= $signed({lmax1[CW], lmax1}) + $signed({rmin1[CW], rmin1});
			cy_s2  <= (p_s1.a_top < p_s1.b_top) ? p_s1.a_top : p_s1.b_top;
		end
	end

	// stage 3: separations per axis
	function automatic logic [MW-1:0] abs_mag(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] a;
		a = v[DW-1] ? -v : v;
		return a[MW-1:0];
	endfunction

	logic [MW-1:0]        mag_ax2, mag_bx2, mag_ay2, mag_by2;
	box_in_t              p_s3;
	logic                 hit_s3, ltx_s3, lty_s3;
	logic signed [DW-1:0] sum_s3;
	coord_t               cy_s3;
	logic [MW-1:0]        dx_s3, dy_s3;

	assign mag_ax2 = abs_mag(dax_s2);
	assign mag_bx2 = abs_mag(dbx_s2);
	assign mag_ay2 = abs_mag(day_s2);
	assign mag_by2 = abs_mag(dby_s2);

	always_ff @(posedge clk) begin
		if (en3) begin
			p_s3   <= p_s2;
			hit_s3 <= hit_s2;
			ltx_s3 <= ltx_s2;
			lty_s3 <= lty_s2;
			sum_s3 <= sum_s2;
			cy_s3  <= cy_s2;
			dx_s3  <= (mag_ax2 < mag_bx2) ? mag_ax2 : mag_bx2;
			dy_s3  <= (mag_ay2 < mag_by2) ? mag_ay2 : mag_by2;
		end
	end

	// stage 4: axis choice and direction
	logic                 use_x3;
	push_t                ctl3;
	box_in_t              p_s4;
	logic signed [DW-1:0] sum_s4;
	coord_t               cy_s4;
	push_t                ctl_s4;
	logic                 small_s4;

	assign use_x3 = dx_s3 < dy_s3;

	always_comb begin
		ctl3.hit = hit_s3;
		ctl3.mag = use_x3 ? dx_s3 : dy_s3;
		if (!hit_s3) begin
			ctl3.side = SIDE_NONE;
		end else if (use_x3) begin
			ctl3.side = ltx_s3 ? SIDE_PX : SIDE_NX;
		end else begin
			ctl3.side = lty_s3 ? SIDE_PY : SIDE_NY;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			p_s4     <= p_s3;
			sum_s4   <= sum_s3;
			cy_s4    <= cy_s3;
			ctl_s4   <= ctl3;
			small_s4 <= ctl3.mag < {{(MW-SW){1'b0}}, smooth_limit_q};
		end
	end

	// stage 5: short push scaled by frame time
	logic [SW+FTW-1:0]    prod4;
	push_t                ctl4;
	box_in_t              p_s5;
	logic signed [DW-1:0] sum_s5;
	coord_t               cy_s5;
	push_t                ctl_s5;

	assign prod4 = (SW+FTW)'(ctl_s4.mag[SW-1:0]) * (SW+FTW)'(frame_time_q);

	always_comb begin
		ctl4 = ctl_s4;
		if (small_s4) ctl4.mag = {{(MW-SW){1'b0}}, prod4[SW+FTW-1:FTW]};
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			p_s5   <= p_s4;
			sum_s5 <= sum_s4;
			cy_s5  <= cy_s4;
			ctl_s5 <= ctl4;
		end
	end

	// stage 6: apply push, result register
	box_out_t res5;
	box_out_t res_s6;

	bpcr_apply u_apply (
		.pair (p_s5),
		.ctl  (ctl_s5),
		.csum (sum_s5),
		.cmin (cy_s5),
		.res  (res5)
	);

	always_ff @(posedge clk) begin
		if (en6) res_s6 <= res5;
	end

	assign res_valid = v_s6;
	assign res       = res_s6;

	// checks
	a_nohit_noside: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.contact_side == SIDE_NONE)
		else $error("contact side set without overlap");

	a_hit_side: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.hit |-> res.contact_side != SIDE_NONE)
		else $error("overlap without contact side");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && res_stall |-> pair_stall)
		else $error("pipeline full and stalled but input not stalled");

	a_px_vel: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.contact_side == SIDE_PX |-> !(res.new_a_vel_x > 0))
		else $error("velocity into +x contact not cleared");

endmodule
